FILE: rtl/core/mmn_pkg.sv
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared widths, register indexes and controller/datapath handshake types for
// the min-max normaliser.
// ----------------------------------------------------------------------------
package mmn_pkg;

    localparam int MAX_LEN_DEF = 64;   // default sample store depth
    localparam int DATA_W      = 16;   // Q8.8 sample width
    localparam int RATIO_W     = 32;   // magnitude of the Q16.16 scale ratio
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic div_start;  // load the ratio divider
        logic walk;       // issue store reads while the pipeline advances
        logic clear;      // return fill count, min, max and overflow to zero
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
        logic walk_end;   // final store read issued this cycle
        logic pipe_empty; // no beat in flight or waiting at the output
    } t_status;

endpackage

FILE: rtl/core/mmn_div.sv
// ----------------------------------------------------------------------------
// mmn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmn_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mmn_pkg::RATIO_W-1:0]  i_dividend,
    input  logic [mmn_pkg::DATA_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic [mmn_pkg::RATIO_W-1:0]  o_quotient
);
    import mmn_pkg::*;

    localparam int CNT_W = $clog2(RATIO_W + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic [DATA_W-1:0]  r_rem;
    logic [RATIO_W-1:0] r_quo;
    logic [DATA_W-1:0]  r_div;

    logic [DATA_W:0]    w_trial;
    logic               w_fits;

    // shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[RATIO_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(RATIO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_fits ? DATA_W'(w_trial - {1'b0, r_div}) : w_trial[DATA_W-1:0];
            r_quo <= {r_quo[RATIO_W-2:0], w_fits};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/mmn_ctrl.sv
// ----------------------------------------------------------------------------
// mmn_ctrl
// Sequencer: load the vector, run the divide, walk the store, drain.
// ----------------------------------------------------------------------------
module mmn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last,
    output logic              o_in_ready,
    output mmn_pkg::t_cmd     o_cmd,
    input  mmn_pkg::t_status  i_status
);
    import mmn_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DIVST = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  if (w_accept && i_last) n_state = ST_DIVST;
            ST_DIVST: n_state = ST_DIV;
            ST_DIV:   if (!i_status.div_busy) n_state = ST_WALK;
            ST_WALK:  if (i_status.walk_end) n_state = ST_DRAIN;
            ST_DRAIN: if (i_status.pipe_empty) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept    = w_accept;
    assign o_cmd.div_start = (r_state == ST_DIVST);
    assign o_cmd.walk      = (r_state == ST_WALK);
    assign o_cmd.clear     = (r_state == ST_DRAIN) && i_status.pipe_empty;

endmodule

FILE: rtl/core/mmn_dp.sv
// ----------------------------------------------------------------------------
// mmn_dp
// Datapath: range registers, sample store, running min/max, ratio divider
// and the three-stage rescale pipeline ending in the output register.
// ----------------------------------------------------------------------------
module mmn_dp #(
    parameter int MAX_LEN = mmn_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mmn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mmn_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic signed [mmn_pkg::DATA_W-1:0] i_sample,
    input  mmn_pkg::t_cmd                  i_cmd,
    output mmn_pkg::t_status               o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [mmn_pkg::DATA_W-1:0] o_value,
    output logic                           o_last_out,
    output logic                           o_dropped
);
    import mmn_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = DATA_W + RATIO_W;

    // range registers
    logic signed [DATA_W-1:0] r_out_low;
    logic signed [DATA_W-1:0] r_out_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_low  <= '0;
            r_out_high <= DATA_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OUT_LOW:  r_out_low  <= i_cfg_data;
                CFG_OUT_HIGH: r_out_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vector capture
    logic [DATA_W-1:0]        r_mem [MAX_LEN];
    logic [CW-1:0]            r_fill;
    logic signed [DATA_W-1:0] r_min;
    logic signed [DATA_W-1:0] r_max;
    logic                     r_ovf;
    logic                     w_room;

    assign w_room = (r_fill < CW'(MAX_LEN));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_room) begin
            r_mem[r_fill[AW-1:0]] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fill <= '0;
            r_min  <= '0;
            r_max  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (w_room) begin
                r_fill <= r_fill + 1'b1;
                if (r_fill == '0) begin
                    r_min <= i_sample;
                    r_max <= i_sample;
                end else begin
                    if (i_sample > r_max) r_max <= i_sample;
                    if (i_sample < r_min) r_min <= i_sample;
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // ratio = (hi - lo) * 2^16 / (max - min), on magnitudes
    logic signed [DATA_W:0] w_range;
    logic                   w_neg;
    logic [DATA_W:0]        w_range_mag;
    logic [DATA_W:0]        w_span;
    logic                   w_span_zero;
    logic [RATIO_W-1:0]     w_quo;
    logic [RATIO_W-1:0]     w_ratio;
    logic                   w_div_busy;

    assign w_range     = (DATA_W+1)'(r_out_high) - (DATA_W+1)'(r_out_low);
    assign w_neg       = w_range[DATA_W];
    assign w_range_mag = w_neg ? (DATA_W+1)'(-w_range) : w_range;
    assign w_span      = (DATA_W+1)'(r_max) - (DATA_W+1)'(r_min);
    assign w_span_zero = (w_span == '0);
    assign w_ratio     = w_span_zero ? '0 : w_quo;

    mmn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_range_mag[DATA_W-1:0], {(RATIO_W-DATA_W){1'b0}}}),
        .i_divisor  (w_span[DATA_W-1:0]),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // rescale pipeline: read, multiply, scale/offset/saturate into output
    logic              w_adv;
    logic              w_issue;
    logic [AW-1:0]     r_addr;
    logic              w_issue_last;

    logic [DATA_W-1:0] r_rd_data;
    logic              r_v1;
    logic              r_l1;
    logic [RATIO_W-1:0] r_prod;
    logic              r_v2;
    logic              r_l2;
    logic              r_out_valid;

    logic signed [DATA_W:0]   w_diff;
    logic [PW-1:0]            w_prod;
    logic signed [DATA_W+1:0] w_sh;
    logic signed [DATA_W+1:0] w_scaled;
    logic signed [DATA_W+1:0] w_sum;
    logic signed [DATA_W-1:0] w_sat;

    // hold every stage while the output beat waits
    assign w_adv        = !r_out_valid || i_out_ready;
    assign w_issue      = i_cmd.walk && w_adv;
    assign w_issue_last = ((CW'(r_addr) + 1'b1) == r_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_addr <= '0;
        end else if (w_issue) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_data <= r_mem[r_addr];
            r_l1      <= w_issue_last;
        end
    end

    // sample - min is non-negative and below 2^16
    assign w_diff = (DATA_W+1)'($signed(r_rd_data)) - (DATA_W+1)'(r_min);
    assign w_prod = PW'(w_diff[DATA_W-1:0]) * PW'(w_ratio);

    // (x-min)*|ratio| never exceeds |hi-lo|*2^16, so the low word holds it
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= w_prod[RATIO_W-1:0];
            r_l2   <= r_l1;
        end
    end

    assign w_sh     = $signed({2'b00, r_prod[RATIO_W-1:RATIO_W-DATA_W]});
    assign w_scaled = w_neg ? -w_sh : w_sh;
    assign w_sum    = w_scaled + (DATA_W+2)'(r_out_low);

    always_comb begin
        priority if (w_sum > (DATA_W+2)'(32767)) begin
            w_sat = 16'sh7fff;
        end else if (w_sum < -(DATA_W+2)'(32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= w_issue;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_value    <= w_sat;
            o_last_out <= r_l2;
            o_dropped  <= r_l2 && r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_status.div_busy   = w_div_busy;
    assign o_status.walk_end   = w_issue && w_issue_last;
    assign o_status.pipe_empty = !(r_v1 || r_v2 || r_out_valid);

endmodule

FILE: rtl/core/min_max_normalizer_core.sv
// ----------------------------------------------------------------------------
// min_max_normalizer_core
// Min-max normaliser for short vectors of signed Q8.8 samples.
//
// Input channel (i_in_valid / o_in_ready): one sample per beat, i_last marks
// the end of the vector. Samples load at one beat per cycle; beats beyond
// MAX_LEN are discarded and flagged on the final result.
// Output channel (o_out_valid / i_out_ready): one rescaled sample per stored
// element, in arrival order, o_last_out on the final one.
// Configuration: write out_low (index 0) or out_high (index 1) through
// i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// Sequence: after the last input beat, the scale ratio is built by a
// 32-step one-bit-per-cycle divider, then the read, multiply and output
// stages give the first result; further results follow one per cycle
// while the receiver is ready.
// The input side stays closed from the last beat until every result has gone.
// Receiver stall: the whole output pipeline holds, nothing is lost.
// Reset: range returns to [0, 256], the vector is emptied, no result pending.
// ----------------------------------------------------------------------------
module min_max_normalizer_core #(
    parameter int MAX_LEN = mmn_pkg::MAX_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [mmn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mmn_pkg::DATA_W-1:0]        i_cfg_data,
    // input beats
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [mmn_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_last,
    // output beats
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mmn_pkg::DATA_W-1:0] o_value,
    output logic                              o_last_out,
    output logic                              o_dropped
);
    import mmn_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing: load, divide, walk the store, drain
    mmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // storage, min/max tracking, ratio divider and rescale pipeline
    mmn_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_last_out  (o_last_out),
        .o_dropped   (o_dropped)
    );

endmodule

FILE: verif/min_max_normalizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_max_normalizer_core_tb
// Self-checking bench for the min-max normaliser. It drives vectors of Q8.8
// samples with valid/ready and random idle bursts on both sides, and holds
// the receiver off for one long stretch. It rewrites the output range between
// phases, including both extreme ranges, the inverted range and an empty
// range. Vectors run from one sample up past the store depth. Every result
// beat is compared field by field with a bit-accurate predictor or a pinned value.
// ----------------------------------------------------------------------------
module min_max_normalizer_core_tb;

    import mmn_pkg::*;

    localparam int MAX_LEN       = MAX_LEN_DEF;
    localparam int HALF_PERIOD   = 10;     // 20 ns clock
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;      // idle margin before a register write
    localparam int HOLD_CYCLES   = 200;    // long receiver hold-off
    localparam int TAIL_CYCLES   = 60;     // divider + pipeline, with room to spare
    localparam int QUIET_LIMIT   = 2000;   // cycles with no beat before giving up
    localparam int NUM_PHASES    = 7;      // random phases; the last has no idling

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_OUT_LOW;
    logic [DATA_W-1:0]     i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic signed [DATA_W-1:0] i_sample = '0;
    logic                  i_last      = 1'b0;
    logic                  i_out_ready = 1'b0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic signed [DATA_W-1:0] o_value;
    logic                  o_last_out;
    logic                  o_dropped;

    always #HALF_PERIOD i_clk = ~i_clk;

    min_max_normalizer_core #(
        .MAX_LEN     (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_last_out  (o_last_out),
        .o_dropped   (o_dropped)
    );

    // ------------------------------------------------------------------------
    // Directed stimulus table. A pinned row carries the value its sample must
    // map to, typed in by hand; all other rows rely on the predictor alone.
    // ------------------------------------------------------------------------
    typedef enum {ROW_BEAT, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;       // sample or register value
        logic                 last;
        bit                   pinned;
        logic [DATA_W-1:0]    pin_value;
    } t_stim_row;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last_out;
        logic                     dropped;
    } t_norm_beat;

    t_stim_row  stim_rows[$];
    t_norm_beat pending_norm[$];          // normalised beats still owed by the block

    // Predictor state: its own copy of the range and of the vector being built
    logic signed [DATA_W-1:0] range_low  = 16'sd0;
    logic signed [DATA_W-1:0] range_high = 16'sd256;
    logic signed [DATA_W-1:0] sample_mem [MAX_LEN];
    bit                       pin_mem    [MAX_LEN];
    logic signed [DATA_W-1:0] pin_val_mem[MAX_LEN];
    int                       fill_cnt      = 0;
    logic signed [DATA_W-1:0] run_min       = '0;
    logic signed [DATA_W-1:0] run_max       = '0;
    bit                       overflow_flag = 1'b0;

    // Side-band for the beat on the wire: travels with the payload, not to the block
    bit                beat_pinned    = 1'b0;
    logic [DATA_W-1:0] beat_pin_value = '0;

    // Idling controls, set per phase by the main sequence
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;

    // Run statistics
    int fail_count      = 0;
    int beats_in        = 0;
    int beats_out       = 0;
    int vectors_done    = 0;
    int overflow_vecs   = 0;
    int reg_writes      = 0;
    int holds_done      = 0;

    function automatic void append_row(t_stim_row row);
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void add_beat(logic [DATA_W-1:0] smp, logic lst);
        t_stim_row row;
        row = '{ROW_BEAT, CFG_OUT_LOW, smp, lst, 1'b0, '0};
        append_row(row);
    endfunction

    function automatic void add_pinned(logic [DATA_W-1:0] smp, logic lst,
                                       logic [DATA_W-1:0] want);
        t_stim_row row;
        row = '{ROW_BEAT, CFG_OUT_LOW, smp, lst, 1'b1, want};
        append_row(row);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        t_stim_row row;
        row = '{ROW_WRITE, idx, val, 1'b0, 1'b0, '0};
        append_row(row);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: store the sample and track min/max; on the closing beat,
    // rescale the stored vector into the current range and queue the results.
    // ------------------------------------------------------------------------
    function automatic void absorb_sample(logic signed [DATA_W-1:0] x, logic is_last,
                                          bit pin_en, logic [DATA_W-1:0] pin_val);
        longint     span;
        longint     ratio;
        longint     scaled;
        int         k;
        t_norm_beat nb;

        if (fill_cnt < MAX_LEN) begin
            if (fill_cnt == 0) begin
                run_min = x;
                run_max = x;
            end else begin
                if (x > run_max) run_max = x;
                if (x < run_min) run_min = x;
            end
            sample_mem[fill_cnt]  = x;
            pin_mem[fill_cnt]     = pin_en;
            pin_val_mem[fill_cnt] = pin_val;
            fill_cnt++;
        end else begin
            // store full: drop the beat, min and max untouched
            overflow_flag = 1'b1;
        end

        if (!is_last) return;

        // ratio is Q16.16, truncated toward zero; a zero span maps all to low
        span  = longint'(run_max) - longint'(run_min);
        ratio = 0;
        if (span != 0)
            ratio = (longint'(range_high) - longint'(range_low)) * 65536 / span;

        for (k = 0; k < fill_cnt; k++) begin
            if (span != 0)
                scaled = (longint'(sample_mem[k]) - longint'(run_min)) * ratio / 65536
                         + longint'(range_low);
            else
                scaled = longint'(range_low);
            if (scaled > 32767)
                scaled = 32767;
            else if (scaled < -32768)
                scaled = -32768;
            nb.value    = pin_mem[k] ? pin_val_mem[k] : DATA_W'(scaled);
            nb.last_out = (k == fill_cnt - 1);
            nb.dropped  = (k == fill_cnt - 1) ? overflow_flag : 1'b0;
            pending_norm.insert(pending_norm.size(), nb);
        end

        vectors_done++;
        if (overflow_flag) overflow_vecs++;
        fill_cnt      = 0;
        run_min       = '0;
        run_max       = '0;
        overflow_flag = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: sample the handshakes at the rising edge (pre-edge values)
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : in_monitor
        if (i_rst_n && i_in_valid && o_in_ready) begin
            beats_in++;
            absorb_sample(i_sample, i_last, beat_pinned, beat_pin_value);
        end
    end

    always @(posedge i_clk) begin : out_checker
        t_norm_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (pending_norm.size() == 0) begin
                $error("unexpected result beat: value %0d, last_out %0b, dropped %0b",
                       o_value, o_last_out, o_dropped);
                fail_count++;
            end else begin
                want = pending_norm.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0d, actual %0d", want.value, o_value);
                    fail_count++;
                end
                if (o_last_out !== want.last_out) begin
                    $error("last_out: expected %0b, actual %0b", want.last_out, o_last_out);
                    fail_count++;
                end
                if (o_dropped !== want.dropped) begin
                    $error("dropped: expected %0b, actual %0b", want.dropped, o_dropped);
                    fail_count++;
                end
            end
        end
    end

    // Give up once nothing has moved for far longer than any correct stall
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request so the
    // output pipeline backs up and the input side closes
    // ------------------------------------------------------------------------
    initial begin : receiver
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (rx_stall_pct != 0 && $urandom_range(99, 0) < rx_stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(18, 1)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one beat, optionally after an idle burst, and hold it until taken
    task automatic send_beat(logic [DATA_W-1:0] smp, logic lst, bit pin_en,
                             logic [DATA_W-1:0] pin_val);
        if (tx_gap_pct != 0 && $urandom_range(99, 0) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample       <= smp;
        i_last         <= lst;
        beat_pinned    <= pin_en;
        beat_pin_value <= pin_val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, then wait for every owed result plus a short idle margin.
    // Wait for a clock edge first so the monitor has queued the closing beat's results.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_norm.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write, then the write port goes quiet before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_OUT_LOW)
            range_low = val;
        else
            range_high = val;
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Pick a sample in the flavour chosen for the vector
    function automatic logic [DATA_W-1:0] pick_sample(int flavour, logic [DATA_W-1:0] centre);
        case (flavour)
            5, 6, 7: return centre + DATA_W'($urandom_range(7, 0)); // tight span, big ratio
            8:       return centre;                                  // all equal
            9: begin
                case ($urandom_range(3, 0))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return DATA_W'($urandom);                       // full range
        endcase
    endfunction

    task automatic send_vector(int len);
        int                flavour;
        int                k;
        logic [DATA_W-1:0] centre;
        flavour = $urandom_range(9, 0);
        centre  = DATA_W'($urandom);
        for (k = 0; k < len; k++)
            send_beat(pick_sample(flavour, centre), k == len - 1, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int                p;
        int                v;
        int                len;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;

        // After reset the range is [0, 256]; a lone sample maps to the low end
        add_pinned(16'h0000, 1'b1, 16'h0000);
        add_beat(16'h0100, 1'b0);
        add_beat(16'hFF00, 1'b0);
        add_beat(16'h0080, 1'b1);
        // Full-scale range: min and max land exactly on the ends
        add_write(CFG_OUT_LOW,  16'h8000);
        add_write(CFG_OUT_HIGH, 16'h7FFF);
        add_pinned(16'h8000, 1'b0, 16'h8000);
        add_pinned(16'h7FFF, 1'b0, 16'h7FFF);
        add_pinned(16'h0000, 1'b1, 16'h0000);
        // Equal samples: every result is the low end
        add_pinned(16'h1234, 1'b0, 16'h8000);
        add_pinned(16'h1234, 1'b0, 16'h8000);
        add_pinned(16'h1234, 1'b1, 16'h8000);
        // Inverted range: negative ratio, min maps high and max maps low
        add_write(CFG_OUT_LOW,  16'h7FFF);
        add_write(CFG_OUT_HIGH, 16'h8000);
        add_pinned(16'h8000, 1'b0, 16'h7FFF);
        add_pinned(16'h7FFF, 1'b1, 16'h8000);
        add_beat(16'd100, 1'b0);
        add_beat(-16'sd7, 1'b0);
        add_beat(16'd3,   1'b1);
        // Empty range: zero ratio, everything maps to the shared end
        add_write(CFG_OUT_LOW,  16'h0500);
        add_write(CFG_OUT_HIGH, 16'h0500);
        add_pinned(16'h0001, 1'b0, 16'h0500);
        add_pinned(16'hFFFF, 1'b1, 16'h0500);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table with light idling on both sides
        tx_gap_pct   = 25;
        rx_stall_pct = 25;
        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_WRITE) begin
                settle();
                write_reg(stim_rows[r].idx, stim_rows[r].data);
            end else begin
                send_beat(stim_rows[r].data, stim_rows[r].last,
                          stim_rows[r].pinned, stim_rows[r].pin_value);
            end
        end

        // Random phases: new range each time, short vectors, one vector past
        // the store depth, and a clean run at the end
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                1: begin lo = 16'h0000; hi = 16'h0100; end
                2: begin lo = 16'h8000; hi = 16'h7FFF; end
                3: begin lo = 16'h7FFF; hi = 16'h8000; end
                4: begin lo = DATA_W'($urandom); hi = lo; end
                5: begin lo = DATA_W'($urandom); hi = lo + DATA_W'($urandom_range(512, 0)); end
                default: begin lo = DATA_W'($urandom); hi = DATA_W'($urandom); end
            endcase
            if ($urandom_range(1, 0)) begin
                write_reg(CFG_OUT_LOW,  lo);
                write_reg(CFG_OUT_HIGH, hi);
            end else begin
                write_reg(CFG_OUT_HIGH, hi);
                write_reg(CFG_OUT_LOW,  lo);
            end

            if (p == NUM_PHASES - 1) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else if (p % 3 == 0) begin
                tx_gap_pct   = 0;
                rx_stall_pct = $urandom_range(40, 5);
            end else begin
                tx_gap_pct   = $urandom_range(40, 5);
                rx_stall_pct = $urandom_range(40, 0);
            end

            // Hold the receiver off while a vector arrives back to back and
            // the next one is already on offer
            if (p == 1) begin
                hold_req   = 1'b1;
                tx_gap_pct = 0;
            end

            // One past full: the closing beat itself is dropped
            if (p == 3) begin
                send_vector(MAX_LEN + 1);
            end else begin
                for (v = 0; v < ((p == 1) ? 2 : 1); v++) begin
                    if (p == 1 && v == 0)
                        len = 10;
                    else
                        len = $urandom_range(5, 1);
                    send_vector(len);
                end
            end
        end

        // Drain: everything owed, then enough cycles for any stray beat to show
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_norm.size() != 0) begin
            $error("%0d normalised beats never arrived", pending_norm.size());
            fail_count++;
        end

        $display("Run covered %0d sample beats in %0d vectors (%0d over the store depth)",
                 beats_in, vectors_done, overflow_vecs);
        $display("and %0d result beats, %0d range writes, %0d long receiver hold-offs",
                 beats_out, reg_writes, holds_done);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mmn_pkg.sv
rtl/core/mmn_div.sv
rtl/core/mmn_ctrl.sv
rtl/core/mmn_dp.sv
rtl/core/min_max_normalizer_core.sv
verif/min_max_normalizer_core_tb.sv
